@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_PROP(lbl, ck, rn, prop) \
    lbl: assert property (@(posedge ck) disable iff (!rn) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(lbl, ck, rn, expr) \
    lbl: assert property (@(posedge ck) disable iff (!rn) !(expr)) \
        else $error("forbidden condition");
`else
`define ASSERT_PROP(lbl, ck, rn, prop)
`define ASSERT_NEVER(lbl, ck, rn, expr)
`endif

`endif

@@ hw/rtl/salc_pkg.sv @@
// ----------------------------------------------------------------------------
// salc_pkg
// Shared constants and types of the set-associative LRU cache model.
// ----------------------------------------------------------------------------
`default_nettype none

package salc_pkg;

    localparam int MAX_SET_BITS = 8;
    localparam int MAX_WAYS     = 8;
    localparam int NUM_SETS     = 1 << MAX_SET_BITS;
    localparam int SET_W        = MAX_SET_BITS;
    localparam int WAY_W        = $clog2(MAX_WAYS);
    localparam int NWAY_W       = 4;
    localparam int RANK_W       = 4;
    localparam int ADDR_W       = 63;
    localparam int TAG_W        = 63;
    localparam int SETB_W       = 4;
    localparam int BLKB_W       = 6;
    localparam int CNT_W        = 32;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 6;

    localparam logic [CFG_IDX_W-1:0] REG_SET_BITS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WAYS_USED  = 2'd2;

    localparam logic [1:0] FUNC_LOAD   = 2'd0;
    localparam logic [1:0] FUNC_STORE  = 2'd1;
    localparam logic [1:0] FUNC_MODIFY = 2'd2;

    localparam logic [1:0] OUT_HIT   = 2'd0;
    localparam logic [1:0] OUT_FILL  = 2'd1;
    localparam logic [1:0] OUT_EVICT = 2'd2;

    typedef struct packed {
        logic accept;
        logic update;
    } salc_cmd_t;

    typedef struct packed {
        logic [MAX_WAYS-1:0]             valid;
        logic [MAX_WAYS-1:0][TAG_W-1:0]  tag;
        logic [MAX_WAYS-1:0][RANK_W-1:0] rank;
    } salc_row_t;

endpackage

`default_nettype wire

@@ hw/rtl/salc_ctrl.sv @@
// ----------------------------------------------------------------------------
// salc_ctrl
// Request sequencer: takes a request, runs the row update, holds result valid.
// ----------------------------------------------------------------------------
`default_nettype none

module salc_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output salc_pkg::salc_cmd_t    cmd
);

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_UPDATE = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic slot_free;

    always_comb
    begin
        slot_free      = !out_valid_reg || !out_stall;
        cmd.accept     = 1'b0;
        cmd.update     = 1'b0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (slot_free)
                begin
                    cmd.update     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

@@ hw/rtl/salc_dpath.sv @@
// ----------------------------------------------------------------------------
// salc_dpath
// Address split, set row memory, tag match, LRU rank update and totals.
// ----------------------------------------------------------------------------
`default_nettype none

module salc_dpath (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [salc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [salc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire salc_pkg::salc_cmd_t              cmd,
    input  wire logic [1:0]                       func,
    input  wire logic [salc_pkg::ADDR_W-1:0]      address,
    output logic [1:0]                            outcome,
    output logic                                  modify_extra_hit,
    output logic [salc_pkg::CNT_W-1:0]            total_hits,
    output logic [salc_pkg::CNT_W-1:0]            total_misses,
    output logic [salc_pkg::CNT_W-1:0]            total_evictions
);

    // config
    logic [salc_pkg::SETB_W-1:0] set_bits_reg;
    logic [salc_pkg::BLKB_W-1:0] block_bits_reg;
    logic [salc_pkg::NWAY_W-1:0] ways_used_reg;
    logic [salc_pkg::SETB_W-1:0] sb_eff;
    logic [salc_pkg::NWAY_W-1:0] nways_eff;

    // address split
    logic [salc_pkg::ADDR_W-1:0] rest;
    logic [salc_pkg::SET_W-1:0]  set_mask;
    logic [salc_pkg::SET_W-1:0]  set_idx;
    logic [salc_pkg::TAG_W-1:0]  tag_in;

    // request registers
    logic [salc_pkg::SET_W-1:0]  set_reg;
    logic [salc_pkg::TAG_W-1:0]  tag_reg;
    logic                        extra_reg;
    logic                        row_ok_reg;
    salc_pkg::salc_row_t         rd_row_reg;

    // memory and per-set valid
    salc_pkg::salc_row_t         mem [salc_pkg::NUM_SETS];
    logic [salc_pkg::NUM_SETS-1:0] set_valid_reg;

    // update
    salc_pkg::salc_row_t         cur;
    salc_pkg::salc_row_t         row_new;
    logic [salc_pkg::MAX_WAYS-1:0] in_use;
    logic [salc_pkg::MAX_WAYS-1:0] hit_vec;
    logic [salc_pkg::MAX_WAYS-1:0] free_vec;
    logic                        hit_any;
    logic                        free_any;
    logic [salc_pkg::WAY_W-1:0]  hit_idx;
    logic [salc_pkg::WAY_W-1:0]  free_idx;
    logic [salc_pkg::WAY_W-1:0]  victim;
    logic [salc_pkg::WAY_W-1:0]  sel;
    logic [salc_pkg::RANK_W-1:0] old_rank;
    logic [1:0]                  outcome_new;
    logic [1:0]                  hit_add;

    logic [salc_pkg::CNT_W-1:0]  hits_reg;
    logic [salc_pkg::CNT_W-1:0]  misses_reg;
    logic [salc_pkg::CNT_W-1:0]  evicts_reg;
    logic [salc_pkg::CNT_W-1:0]  hits_next;
    logic [salc_pkg::CNT_W-1:0]  misses_next;
    logic [salc_pkg::CNT_W-1:0]  evicts_next;
    logic [1:0]                  outcome_reg;
    logic                        modify_reg;

    function automatic logic [salc_pkg::CNT_W-1:0] sat_add(
        input logic [salc_pkg::CNT_W-1:0] v,
        input logic [1:0]                 inc
    );
        logic [salc_pkg::CNT_W+1:0] sum;
        sum = {2'b00, v} + {{salc_pkg::CNT_W{1'b0}}, inc};
        if (sum[salc_pkg::CNT_W+1:salc_pkg::CNT_W] != 2'b00)
            return '1;
        return sum[salc_pkg::CNT_W-1:0];
    endfunction

    assign cfg_ready = 1'b1;

    always_comb
    begin
        if (set_bits_reg > salc_pkg::SETB_W'(salc_pkg::MAX_SET_BITS))
            sb_eff = salc_pkg::SETB_W'(salc_pkg::MAX_SET_BITS);
        else
            sb_eff = set_bits_reg;

        if (ways_used_reg == '0)
            nways_eff = salc_pkg::NWAY_W'(1);
        else if (ways_used_reg > salc_pkg::NWAY_W'(salc_pkg::MAX_WAYS))
            nways_eff = salc_pkg::NWAY_W'(salc_pkg::MAX_WAYS);
        else
            nways_eff = ways_used_reg;

        if (block_bits_reg >= salc_pkg::BLKB_W'(salc_pkg::ADDR_W))
            rest = '0;
        else
            rest = address >> block_bits_reg;

        for (int i = 0; i < salc_pkg::SET_W; i++)
            set_mask[i] = (salc_pkg::SETB_W'(i) < sb_eff);

        set_idx = rest[salc_pkg::SET_W-1:0] & set_mask;
        tag_in  = rest >> sb_eff;
    end

    always_comb
    begin
        cur = row_ok_reg ? rd_row_reg : '0;

        for (int i = 0; i < salc_pkg::MAX_WAYS; i++)
        begin
            in_use[i]   = (salc_pkg::NWAY_W'(i) < nways_eff);
            hit_vec[i]  = in_use[i] && cur.valid[i] && (cur.tag[i] == tag_reg);
            free_vec[i] = in_use[i] && !cur.valid[i];
        end
        hit_any  = |hit_vec;
        free_any = |free_vec;

        hit_idx  = '0;
        free_idx = '0;
        for (int i = salc_pkg::MAX_WAYS - 1; i >= 0; i--)
        begin
            if (hit_vec[i])
                hit_idx = salc_pkg::WAY_W'(i);
            if (free_vec[i])
                free_idx = salc_pkg::WAY_W'(i);
        end

        victim = '0;
        for (int i = 1; i < salc_pkg::MAX_WAYS; i++)
        begin
            if (in_use[i] && (cur.rank[i] < cur.rank[victim]))
                victim = salc_pkg::WAY_W'(i);
        end

        if (hit_any)
        begin
            sel         = hit_idx;
            outcome_new = salc_pkg::OUT_HIT;
        end
        else if (free_any)
        begin
            sel         = free_idx;
            outcome_new = salc_pkg::OUT_FILL;
        end
        else
        begin
            sel         = victim;
            outcome_new = salc_pkg::OUT_EVICT;
        end

        old_rank = cur.rank[sel];
        row_new  = cur;
        for (int i = 0; i < salc_pkg::MAX_WAYS; i++)
        begin
            if (in_use[i] && cur.valid[i] && (cur.rank[i] > old_rank))
                row_new.rank[i] = cur.rank[i] - salc_pkg::RANK_W'(1);
        end
        row_new.valid[sel] = 1'b1;
        row_new.tag[sel]   = tag_reg;
        row_new.rank[sel]  = salc_pkg::RANK_W'(nways_eff);

        hit_add     = {1'b0, extra_reg} + {1'b0, hit_any};
        hits_next   = sat_add(hits_reg, hit_add);
        misses_next = sat_add(misses_reg, {1'b0, !hit_any});
        evicts_next = sat_add(evicts_reg, {1'b0, !hit_any && !free_any});
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            rd_row_reg <= mem[set_idx];
            row_ok_reg <= set_valid_reg[set_idx];
            set_reg    <= set_idx;
            tag_reg    <= tag_in;
            extra_reg  <= (func == salc_pkg::FUNC_MODIFY);
        end
        if (cmd.update)
        begin
            mem[set_reg] <= row_new;
            outcome_reg  <= outcome_new;
            modify_reg   <= extra_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_bits_reg   <= '0;
            block_bits_reg <= '0;
            ways_used_reg  <= salc_pkg::NWAY_W'(1);
            set_valid_reg  <= '0;
            hits_reg       <= '0;
            misses_reg     <= '0;
            evicts_reg     <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    salc_pkg::REG_SET_BITS:
                        set_bits_reg <= cfg_data[salc_pkg::SETB_W-1:0];
                    salc_pkg::REG_BLOCK_BITS:
                        block_bits_reg <= cfg_data[salc_pkg::BLKB_W-1:0];
                    salc_pkg::REG_WAYS_USED:
                        ways_used_reg <= cfg_data[salc_pkg::NWAY_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.update)
            begin
                set_valid_reg[set_reg] <= 1'b1;
                hits_reg               <= hits_next;
                misses_reg             <= misses_next;
                evicts_reg             <= evicts_next;
            end
        end
    end

    assign outcome          = outcome_reg;
    assign modify_extra_hit = modify_reg;
    assign total_hits       = hits_reg;
    assign total_misses     = misses_reg;
    assign total_evictions  = evicts_reg;

endmodule

`default_nettype wire

@@ hw/rtl/set_assoc_lru_cache_sim.sv @@
// Request flow: a taken request moves the sequencer from ST_IDLE to ST_UPDATE, where it
// waits for a free output slot, writes the row back and registers out_valid high.
// Requests: in_stall is high in ST_UPDATE, so one request's row read and row write-back
// of the 256-row set memory (one port read, one port write) end before the next is taken.
// Reset: asynchronous; resets control, totals, configuration and the per-set valid
// vector at once, so no clearing pass is needed and requests are taken right away.
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_sim
// Set-associative cache model with LRU replacement and saturating totals.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module set_assoc_lru_cache_sim (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [salc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [salc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [1:0]                       func,
    input  wire logic [salc_pkg::ADDR_W-1:0]      address,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic [1:0]                            outcome,
    output logic                                  modify_extra_hit,
    output logic [salc_pkg::CNT_W-1:0]            total_hits,
    output logic [salc_pkg::CNT_W-1:0]            total_misses,
    output logic [salc_pkg::CNT_W-1:0]            total_evictions
);

    salc_pkg::salc_cmd_t cmd;

    salc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    salc_dpath u_dpath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .cmd              (cmd),
        .func             (func),
        .address          (address),
        .outcome          (outcome),
        .modify_extra_hit (modify_extra_hit),
        .total_hits       (total_hits),
        .total_misses     (total_misses),
        .total_evictions  (total_evictions)
    );

    `ASSERT_PROP(a_busy_after_req, clk, rst_n, (in_valid && !in_stall) |=> in_stall)
    `ASSERT_PROP(a_result_from_work, clk, rst_n, $rose(out_valid) |-> $past(in_stall))
    `ASSERT_NEVER(a_update_and_accept, clk, rst_n, cmd.accept && cmd.update)
    `ASSERT_NEVER(a_evict_le_miss, clk, rst_n, total_evictions > total_misses)

endmodule

`default_nettype wire
